// ===== hw/rtl/lrsgd_pkg.sv =====
// Shared types, codes and the sigmoid table of the logistic-regression SGD block.
`default_nettype none
package lrsgd_pkg;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_FEAT_MUL,
        ST_FEAT_ADD,
        ST_SIG_LOAD,
        ST_SIG_ERR,
        ST_SIG_COEF,
        ST_UPD_RD,
        ST_UPD_MUL,
        ST_UPD_WR,
        ST_PRED,
        ST_RDOUT
    } state_t;

    localparam logic [1:0] ACT_WR_WEIGHT = 2'd0;
    localparam logic [1:0] ACT_FEATURE   = 2'd1;
    localparam logic [1:0] ACT_READ      = 2'd2;
    localparam logic [1:0] ACT_CLEAR     = 2'd3;

    localparam logic [1:0] CFG_LEARN_RATE  = 2'd0;
    localparam logic [1:0] CFG_REG_WEIGHT  = 2'd1;
    localparam logic [1:0] CFG_UPDATE_MODE = 2'd2;

    localparam logic       KIND_PRED = 1'b0;
    localparam logic       KIND_READ = 1'b1;

    localparam logic [15:0] LEARN_RATE_RST = 16'd655;
    localparam logic signed [47:0] SIG_Z_LIMIT = 48'sd524288;

    function automatic logic [16:0] sig_tab(input logic [4:0] k);
        logic [16:0] v;
        unique case (k)
            5'd0:    v = 17'd22;
            5'd1:    v = 17'd60;
            5'd2:    v = 17'd162;
            5'd3:    v = 17'd439;
            5'd4:    v = 17'd1179;
            5'd5:    v = 17'd3108;
            5'd6:    v = 17'd7812;
            5'd7:    v = 17'd17625;
            5'd8:    v = 17'd32768;
            5'd9:    v = 17'd47911;
            5'd10:   v = 17'd57724;
            5'd11:   v = 17'd62428;
            5'd12:   v = 17'd64357;
            5'd13:   v = 17'd65097;
            5'd14:   v = 17'd65374;
            5'd15:   v = 17'd65476;
            default: v = 17'd65514;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/lrsgd_sigmoid.sv =====
// Piecewise-linear sigmoid over [-8,8) with saturation, one register stage inside.
`default_nettype none
module lrsgd_sigmoid
    import lrsgd_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               load,
    input  wire logic signed [47:0] z,
    output logic [16:0]             h
);

    logic [16:0] lo_reg, lo_next;
    logic [16:0] diff_reg, diff_next;
    logic [15:0] frac_reg, frac_next;
    logic [19:0] u;
    logic [16:0] hi;
    logic [32:0] prod;

    always_comb begin
        u         = 20'(z + SIG_Z_LIMIT);
        lo_next   = sig_tab({1'b0, u[19:16]});
        hi        = sig_tab(5'({1'b0, u[19:16]} + 5'd1));
        diff_next = hi - lo_next;
        frac_next = u[15:0];
        if (z < -SIG_Z_LIMIT) begin
            lo_next   = sig_tab(5'd0);
            diff_next = 17'd0;
        end else if (z >= SIG_Z_LIMIT) begin
            lo_next   = sig_tab(5'd16);
            diff_next = 17'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            lo_reg   <= lo_next;
            diff_reg <= diff_next;
            frac_reg <= frac_next;
        end
    end

    assign prod = 33'(diff_reg) * 33'(frac_reg);
    assign h    = lo_reg + prod[32:16];

endmodule
`default_nettype wire

// ===== hw/rtl/logistic_regression_sgd_step.sv =====
// Top level of the logistic-regression SGD step with L2 regularization.
// A write-weight request is stored straight into the weight memory. A feature element
// goes through weight read, 32x32 product and saturating accumulate. The last element of
// a sample then goes through the sigmoid and coefficient steps and, per element, through
// read of the weight, delta and sample memories, multiply and write back to the weight or
// delta memory (by update mode) for the update, then emits the prediction. A read goes
// through the memory read and the output wait. After reset and after each clear-delta
// request the delta memory is swept to zero, during which no request is taken; configuration writes are always taken.
`default_nettype none
module logistic_regression_sgd_step
    import lrsgd_pkg::*;
#(
    parameter int MAX_DIM = 64
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [39:0] s_tdata,   // elem_index[5:0], elem_value[37:6], label[38]
    input  wire logic [1:0]  s_tuser,   // action[1:0]
    input  wire logic        s_tlast,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [87:0]      m_tdata,   // prediction[16:0], weight_out[48:17], delta_out[80:49]
    output logic             m_tuser,   // result_kind
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);

    localparam int AW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int CW = $clog2(MAX_DIM + 1);

    logic [AW-1:0] mod_tab [64];
    for (genvar g = 0; g < 64; g++) begin : g_mod
        assign mod_tab[g] = AW'(g % MAX_DIM);
    end

    logic signed [31:0] weights_mem [MAX_DIM];
    logic signed [31:0] delta_mem   [MAX_DIM];
    logic signed [31:0] sample_mem  [MAX_DIM];

    state_t state_reg, state_next;

    logic [15:0] alpha_reg;
    logic [15:0] beta_reg;
    logic        mode_reg;

    logic [AW-1:0]      idx_reg;
    logic signed [31:0] val_reg;
    logic               label_reg;
    logic               last_reg;
    logic [1:0]         act_reg;
    logic [AW-1:0]      clr_reg;
    logic [CW-1:0]      cnt_reg;
    logic [CW-1:0]      upd_reg;
    logic signed [47:0] dot_reg;
    logic signed [63:0] fprod_reg;
    logic [16:0]        h_reg;
    logic signed [17:0] err_reg;
    logic signed [17:0] c1_reg;
    logic [16:0]        c2_reg;
    logic signed [49:0] p1_reg;
    logic signed [49:0] p2_reg;
    logic signed [31:0] tgt_reg;

    logic signed [31:0] w_rd, d_rd, s_rd;

    logic          accept;
    logic          out_free;
    logic [AW-1:0] in_idx;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] upd_addr;
    logic [16:0]   sig_h;

    logic                m_tvalid_reg;
    logic [87:0]         m_tdata_reg;
    logic                m_tuser_reg;

    assign in_idx   = mod_tab[s_tdata[5:0]];
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign upd_addr = upd_reg[AW-1:0];
    assign cfg_ready = 1'b1;

    always_comb begin
        unique case (state_reg)
            ST_IDLE:   rd_addr = in_idx;
            ST_UPD_RD: rd_addr = upd_addr;
            default:   rd_addr = idx_reg;
        endcase
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:    if (clr_reg == AW'(MAX_DIM - 1)) state_next = ST_IDLE;
            ST_IDLE: begin
                if (accept) begin
                    unique case (s_tuser)
                        ACT_FEATURE: state_next = ST_FEAT_MUL;
                        ACT_READ:    state_next = ST_RDOUT;
                        ACT_CLEAR:   state_next = ST_CLEAR;
                        default:     state_next = ST_IDLE;
                    endcase
                end
            end
            ST_FEAT_MUL: state_next = ST_FEAT_ADD;
            ST_FEAT_ADD: state_next = last_reg ? ST_SIG_LOAD : ST_IDLE;
            ST_SIG_LOAD: state_next = ST_SIG_ERR;
            ST_SIG_ERR:  state_next = ST_SIG_COEF;
            ST_SIG_COEF: state_next = ST_UPD_RD;
            ST_UPD_RD:   state_next = ST_UPD_MUL;
            ST_UPD_MUL:  state_next = ST_UPD_WR;
            ST_UPD_WR:   state_next = (CW'(upd_reg + 1'b1) == cnt_reg) ? ST_PRED : ST_UPD_RD;
            ST_PRED:     if (out_free) state_next = ST_IDLE;
            ST_RDOUT:    if (out_free) state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        s_tready = (state_reg == ST_IDLE);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            alpha_reg <= LEARN_RATE_RST;
            beta_reg  <= 16'd0;
            mode_reg  <= 1'b0;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_LEARN_RATE:  alpha_reg <= cfg_data;
                CFG_REG_WEIGHT:  beta_reg  <= cfg_data;
                CFG_UPDATE_MODE: mode_reg  <= cfg_data[0];
                default:         ;
            endcase
        end
    end

    // memories
    logic signed [34:0] term;
    logic signed [35:0] upd_sum;
    logic signed [31:0] upd_sat;

    always_comb begin
        term    = 35'(p1_reg >>> 16) - 35'(p2_reg >>> 16);
        upd_sum = 36'(tgt_reg) + 36'(term);
        if (upd_sum > 36'sd2147483647)       upd_sat = 32'sh7FFFFFFF;
        else if (upd_sum < -36'sd2147483648) upd_sat = 32'sh80000000;
        else                                 upd_sat = upd_sum[31:0];
    end

    always_ff @(posedge aclk) begin
        if (accept && s_tuser == ACT_WR_WEIGHT) begin
            weights_mem[in_idx] <= s_tdata[37:6];
        end else if (state_reg == ST_UPD_WR && mode_reg) begin
            weights_mem[upd_addr] <= upd_sat;
        end
        w_rd <= weights_mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_CLEAR) begin
            delta_mem[clr_reg] <= 32'sd0;
        end else if (state_reg == ST_UPD_WR && !mode_reg) begin
            delta_mem[upd_addr] <= upd_sat;
        end
        d_rd <= delta_mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (accept && s_tuser == ACT_FEATURE) begin
            sample_mem[in_idx] <= s_tdata[37:6];
        end
        s_rd <= sample_mem[rd_addr];
    end

    lrsgd_sigmoid u_sigmoid (
        .aclk (aclk),
        .load (state_reg == ST_SIG_LOAD),
        .z    (dot_reg),
        .h    (sig_h)
    );

    // datapath
    logic signed [47:0] fsh;
    logic signed [48:0] dsum;
    logic signed [34:0] c1_prod;
    logic [31:0]        ab;

    assign fsh     = 48'(fprod_reg >>> 16);
    assign dsum    = 49'(dot_reg) + 49'(fsh);
    assign c1_prod = $signed({19'd0, alpha_reg}) * 35'(err_reg);
    assign ab      = alpha_reg * beta_reg;

    always_ff @(posedge aclk) begin
        if (accept) begin
            idx_reg   <= in_idx;
            val_reg   <= s_tdata[37:6];
            label_reg <= s_tdata[38];
            last_reg  <= s_tlast;
            act_reg   <= s_tuser;
        end
        fprod_reg <= val_reg * w_rd;
        if (state_reg == ST_SIG_ERR) begin
            h_reg   <= sig_h;
            err_reg <= $signed({1'b0, label_reg, 16'd0}) - $signed({1'b0, sig_h});
        end
        if (state_reg == ST_SIG_COEF) begin
            c1_reg <= 18'(c1_prod >>> 16);
            c2_reg <= ab[31:15];
        end
        if (state_reg == ST_UPD_MUL) begin
            p1_reg  <= 50'(c1_reg) * 50'(s_rd);
            p2_reg  <= $signed({33'd0, c2_reg}) * 50'(w_rd);
            tgt_reg <= mode_reg ? w_rd : d_rd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_reg <= '0;
            cnt_reg <= '0;
            upd_reg <= '0;
            dot_reg <= '0;
        end else begin
            if (state_reg == ST_CLEAR) begin
                clr_reg <= (clr_reg == AW'(MAX_DIM - 1)) ? '0 : AW'(clr_reg + 1'b1);
            end
            if (state_reg == ST_FEAT_ADD) begin
                if (dsum > 49'sh0_7FFF_FFFF_FFFF)       dot_reg <= 48'sh7FFF_FFFF_FFFF;
                else if (dsum < -49'sh0_8000_0000_0000) dot_reg <= 48'sh8000_0000_0000;
                else                                    dot_reg <= dsum[47:0];
                if (cnt_reg != CW'(MAX_DIM)) cnt_reg <= CW'(cnt_reg + 1'b1);
            end
            if (state_reg == ST_SIG_COEF) upd_reg <= '0;
            if (state_reg == ST_UPD_WR)   upd_reg <= CW'(upd_reg + 1'b1);
            if (state_reg == ST_PRED && out_free) begin
                dot_reg <= '0;
                cnt_reg <= '0;
            end
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (out_free) begin
            m_tvalid_reg <= (state_reg == ST_PRED) || (state_reg == ST_RDOUT);
        end
    end

    always_ff @(posedge aclk) begin
        if (out_free && state_reg == ST_PRED) begin
            m_tuser_reg <= KIND_PRED;
            m_tdata_reg <= {7'd0, 32'd0, 32'd0, h_reg};
        end else if (out_free && state_reg == ST_RDOUT) begin
            m_tuser_reg <= KIND_READ;
            m_tdata_reg <= {7'd0, d_rd, w_rd, 17'd0};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    ap_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CW'(MAX_DIM)) else $error("element count beyond vector size");

    ap_upd_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_UPD_RD || state_reg == ST_UPD_MUL || state_reg == ST_UPD_WR)
        |-> upd_reg < cnt_reg) else $error("update index past sample length");

    ap_pred_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser == KIND_PRED) |-> (m_tdata[16:0] <= 17'd65536
        && m_tdata[80:17] == 64'd0)) else $error("malformed prediction");

    ap_feat_seq: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FEAT_ADD) |-> (act_reg == ACT_FEATURE))
        else $error("accumulate without feature request");

endmodule
`default_nettype wire
